// ===== rtl/dwst_pkg.sv =====
// Package for the decaying working-set table: sizes, codes, command/status types.
// Used by every module in rtl/.
package dwst_pkg;

  localparam int MaxSlots   = 8;
  localparam int NumStreams = 3;
  localparam int NumEntries = MaxSlots * NumStreams;
  localparam int SlotW      = $clog2(MaxSlots);
  localparam int AddrW      = $clog2(NumEntries);
  localparam int CntW       = $clog2(MaxSlots + 1);
  localparam int StrW       = 2;
  localparam int NodeW      = 63;
  localparam int QW         = 16;
  localparam int CapW       = 4;

  localparam logic [QW-1:0] OneQ15  = 16'd32768;
  localparam logic [QW-1:0] HalfQ15 = 16'd16384;
  localparam logic [CapW-1:0] CapReset = 4'd4;

  typedef enum logic [2:0] {
    FN_LOAD   = 3'd0,
    FN_REMOVE = 3'd1,
    FN_CLEAR  = 3'd2,
    FN_SETATT = 3'd3,
    FN_DECAY  = 3'd4,
    FN_READ   = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_INSERT  = 3'd1,
    ST_PRESENT = 3'd2,
    ST_REMOVED = 3'd3,
    ST_ATTSET  = 3'd4,
    ST_DECAYED = 3'd5,
    ST_READ    = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SHIFT, S_APPEND, S_ATT, S_DEC_RD, S_DEC_MUL,
    S_DEC_DIV, S_DEC_WR, S_READ, S_DONE
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    logic load_in;      // capture input transaction
    logic scan_clr;     // reset scan position to 0
    logic scan_step;    // advance scan, compare id / track min
    logic shift_step;   // copy k+1 to k, advance
    logic shift_init;   // k <= pick position
    logic append;       // write new slot at len
    logic len_dec;      // length of current stream minus one
    logic clr_len;      // length of current stream to zero
    logic att_wr;       // write attention / activation at found slot
    logic dec_init;     // start decay walk
    logic dec_rd;       // fetch entry
    logic dec_mul;      // product register
    logic dec_div;      // quotient register
    logic dec_wr;       // write back / drop
    logic rd_slot;      // register read result
    logic out_load;     // fill output register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    func_e            func;
    logic             ok;
    logic             scan_end;
    logic             found;
    logic             full;
    logic             room;
    logic             shift_end;
    logic             dec_end;
    logic             stream_end;
  } stat_t;

endpackage

// ===== rtl/dwst_ctrl.sv =====
// Controller FSM for the working-set table: sequences scans, shifts and decay.
// Depends on dwst_pkg.
module dwst_ctrl import dwst_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  logic  out_full_i,
  input  stat_t st_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          cmd_o.scan_clr = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (st_i.func == FN_DECAY) begin
          cmd_o.dec_init = 1'b1;
          state_d = S_DEC_RD;
        end else if (st_i.func == FN_READ) begin
          state_d = S_READ;
        end else if (!st_i.ok) begin
          state_d = S_DONE;
        end else if (st_i.func == FN_CLEAR) begin
          cmd_o.clr_len = 1'b1;
          state_d = S_DONE;
        end else if (st_i.func == FN_LOAD || st_i.func == FN_REMOVE ||
                     st_i.func == FN_SETATT) begin
          if (!st_i.scan_end) begin
            cmd_o.scan_step = 1'b1;
          end else if (st_i.func == FN_LOAD) begin
            if (st_i.found) state_d = S_DONE;
            else if (st_i.full) begin
              cmd_o.shift_init = 1'b1;
              state_d = S_SHIFT;
            end else state_d = S_APPEND;
          end else if (st_i.func == FN_REMOVE) begin
            if (st_i.found) begin
              cmd_o.shift_init = 1'b1;
              state_d = S_SHIFT;
            end else state_d = S_DONE;
          end else begin
            state_d = st_i.found ? S_ATT : S_DONE;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_SHIFT: begin
        if (!st_i.shift_end) begin
          cmd_o.shift_step = 1'b1;
        end else begin
          cmd_o.len_dec = 1'b1;
          state_d = (st_i.func == FN_LOAD) ? S_APPEND : S_DONE;
        end
      end
      S_APPEND: begin
        if (st_i.room) cmd_o.append = 1'b1;
        state_d = S_DONE;
      end
      S_ATT: begin
        cmd_o.att_wr = 1'b1;
        state_d = S_DONE;
      end
      S_DEC_RD: begin
        if (st_i.dec_end) begin
          state_d = S_DONE;
        end else if (st_i.stream_end) begin
          cmd_o.dec_rd = 1'b1;  // moves to next stream
        end else begin
          cmd_o.dec_rd = 1'b1;
          state_d = S_DEC_MUL;
        end
      end
      S_DEC_MUL: begin
        cmd_o.dec_mul = 1'b1;
        state_d = S_DEC_DIV;
      end
      S_DEC_DIV: begin
        cmd_o.dec_div = 1'b1;
        state_d = S_DEC_WR;
      end
      S_DEC_WR: begin
        cmd_o.dec_wr = 1'b1;
        state_d = S_DEC_RD;
      end
      S_READ: begin
        cmd_o.rd_slot = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_full_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE) else $error("ready outside idle");
  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == S_SCAN) else $error("accept lost");
  a_out_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> state_q == S_IDLE) else $error("double result");

endmodule

// ===== rtl/dwst_dp.sv =====
// Datapath for the working-set table: slot memories, scan, shift, decay arithmetic.
// Depends on dwst_pkg.
module dwst_dp import dwst_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic [2:0]        func_i,
  input  logic [StrW-1:0]   stream_i,
  input  logic [NodeW-1:0]  node_id_i,
  input  logic [QW-1:0]     weight_i,
  input  logic [QW-1:0]     tick_length_i,
  input  logic [SlotW-1:0]  slot_index_i,
  input  logic [CapW-1:0]   cap_i,
  output stat_t             st_o,
  output logic [2:0]        status_o,
  output logic              evicted_o,
  output logic [NodeW-1:0]  evicted_node_o,
  output logic [4:0]        dropped_count_o,
  output logic              slot_valid_o,
  output logic [NodeW-1:0]  slot_node_o,
  output logic [QW-1:0]     slot_activation_o,
  output logic [QW-1:0]     slot_attention_o,
  output logic [CntW-1:0]   slot_count_o
);

  logic [NodeW-1:0] ids_q [NumEntries];
  logic [QW-1:0]    act_q [NumEntries];
  logic [QW-1:0]    att_q [NumEntries];
  logic [CntW-1:0]  len_q [NumStreams];

  logic [2:0]       func_q;
  logic [StrW-1:0]  str_q;
  logic [NodeW-1:0] id_q;
  logic [QW-1:0]    w_q, dt_q;
  logic [SlotW-1:0] idx_q;
  logic [CntW-1:0]  k_q;          // scan / shift position
  logic             found_q;
  logic [SlotW-1:0] pos_q;        // match or minimum position
  logic [QW-1:0]    min_q;
  logic             ev_q;
  logic [NodeW-1:0] evn_q;
  logic [2:0]       stat_q;
  logic             rv_q;
  logic [NodeW-1:0] rn_q;
  logic [QW-1:0]    ra_q, rt_q;
  // decay walk
  logic [StrW-1:0]  ds_q;
  logic [CntW-1:0]  dk_q, dw_q;
  logic [4:0]       drop_q;
  logic [QW-1:0]    dact_q, datt_q;
  logic [NodeW-1:0] did_q;
  logic [32:0]      prod_q;       // (65536-att)*dt < 2^33
  logic [23:0]      quo_q;        // quotient < 2^20

  // prod / 10240 = (prod >> 11) / 5; the reciprocal 3355444 / 2^24 is exact
  // for dividends below 2^22.
  localparam logic [21:0] Recip5 = 22'd3355444;
  logic [43:0] qprod;
  assign qprod = 44'(prod_q[32:11]) * 44'(Recip5);

  logic ok;
  logic [CntW-1:0] n;
  logic [AddrW-1:0] base, dbase;
  logic [CapW-1:0] cap;
  assign ok = (str_q < StrW'(NumStreams));
  assign n = ok ? len_q[str_q] : '0;
  assign base = AddrW'(str_q) * AddrW'(MaxSlots);
  assign dbase = AddrW'(ds_q) * AddrW'(MaxSlots);
  assign cap = (cap_i == '0) ? 4'd1 : ((cap_i > CapW'(MaxSlots)) ? CapW'(MaxSlots) : cap_i);

  logic [AddrW-1:0] sa;
  assign sa = base + AddrW'(k_q[SlotW-1:0]);
  logic [SlotW-1:0] ksl;
  assign ksl = k_q[SlotW-1:0];

  // set attention arithmetic
  logic signed [QW-1:0]  ws;
  logic signed [QW:0]    wq;
  logic [QW-1:0] att_new;
  logic signed [QW+1:0] act_sum;
  logic [QW-1:0] act_new;
  logic [QW-1:0] wmag, wdiv;
  assign ws = signed'(w_q);
  assign wmag = ws[QW-1] ? (~w_q + 1'b1) : w_q;
  assign wdiv = QW'((32'(wmag) * 32'd52429) >> 18);
  assign wq = ws[QW-1] ? -$signed({1'b0, wdiv}) : $signed({1'b0, wdiv});
  assign att_new = ws[QW-1] ? '0 : ((w_q > HalfQ15) ? OneQ15 : QW'({w_q, 1'b0}));
  assign act_sum = $signed({2'b0, act_q[base + AddrW'(pos_q)]}) + (QW+2)'(wq);
  assign act_new = act_sum[QW+1] ? '0 :
                   (act_sum > $signed((QW+2)'(OneQ15)) ? OneQ15 : act_sum[QW-1:0]);

  logic [CntW-1:0] dlen;
  assign dlen = (ds_q < StrW'(NumStreams)) ? len_q[ds_q] : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q <= func_i; str_q <= stream_i; id_q <= node_id_i;
      w_q <= weight_i; dt_q <= tick_length_i; idx_q <= slot_index_i;
      ev_q <= 1'b0; evn_q <= '0; drop_q <= '0; rv_q <= 1'b0;
      rn_q <= '0; ra_q <= '0; rt_q <= '0; stat_q <= ST_NONE;
    end
    if (cmd_i.scan_clr) begin
      k_q <= '0; found_q <= 1'b0; pos_q <= '0; min_q <= '1;
    end
    if (cmd_i.scan_step) begin
      k_q <= k_q + 1'b1;
      if (ids_q[sa] == id_q) begin
        found_q <= 1'b1;
        if (func_q == FN_LOAD) stat_q <= ST_PRESENT;
        if (func_q != FN_SETATT || !found_q) pos_q <= ksl;
      end else if (func_q == FN_LOAD && !found_q && act_q[sa] < min_q) begin
        min_q <= act_q[sa]; pos_q <= ksl;
      end
    end
    if (cmd_i.shift_init) begin
      k_q <= CntW'(pos_q);
      if (func_q == FN_LOAD) begin
        ev_q <= 1'b1; evn_q <= ids_q[base + AddrW'(pos_q)];
      end else stat_q <= ST_REMOVED;
    end
    if (cmd_i.shift_step) begin
      ids_q[sa] <= ids_q[sa + 1'b1];
      act_q[sa] <= act_q[sa + 1'b1];
      att_q[sa] <= att_q[sa + 1'b1];
      k_q <= k_q + 1'b1;
    end
    if (cmd_i.append) begin
      ids_q[base + AddrW'(n[SlotW-1:0])] <= id_q;
      act_q[base + AddrW'(n[SlotW-1:0])] <= OneQ15;
      att_q[base + AddrW'(n[SlotW-1:0])] <= HalfQ15;
    end
    if (cmd_i.att_wr) begin
      att_q[base + AddrW'(pos_q)] <= att_new;
      act_q[base + AddrW'(pos_q)] <= act_new;
      stat_q <= ST_ATTSET;
    end
    if (cmd_i.rd_slot) begin
      stat_q <= ST_READ;
      if (CntW'(idx_q) < n) begin
        rv_q <= 1'b1; rn_q <= ids_q[base + AddrW'(idx_q)];
        ra_q <= act_q[base + AddrW'(idx_q)]; rt_q <= att_q[base + AddrW'(idx_q)];
      end
    end
    if (cmd_i.append || (cmd_i.len_dec && func_q == FN_LOAD)) stat_q <= ST_INSERT;
    if (cmd_i.clr_len) stat_q <= ST_REMOVED;
    if (cmd_i.dec_init) begin
      ds_q <= '0; dk_q <= '0; dw_q <= '0; stat_q <= ST_DECAYED;
    end
    if (cmd_i.dec_rd) begin
      if (dk_q >= dlen) begin
        ds_q <= ds_q + 1'b1; dk_q <= '0; dw_q <= '0;
      end else begin
        did_q <= ids_q[dbase + AddrW'(dk_q[SlotW-1:0])];
        dact_q <= act_q[dbase + AddrW'(dk_q[SlotW-1:0])];
        datt_q <= att_q[dbase + AddrW'(dk_q[SlotW-1:0])];
      end
    end
    if (cmd_i.dec_mul) begin
      prod_q <= 33'(17'(18'd65536 - 18'(datt_q)) * 33'(dt_q));
    end
    if (cmd_i.dec_div) begin
      quo_q <= 24'(qprod[43:24]);
    end
    if (cmd_i.dec_wr) begin
      if (24'(dact_q) > quo_q) begin
        ids_q[dbase + AddrW'(dw_q[SlotW-1:0])] <= did_q;
        act_q[dbase + AddrW'(dw_q[SlotW-1:0])] <= dact_q - QW'(quo_q);
        att_q[dbase + AddrW'(dw_q[SlotW-1:0])] <= datt_q;
        dw_q <= dw_q + 1'b1;
      end else drop_q <= drop_q + 1'b1;
      dk_q <= dk_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumStreams; i++) len_q[i] <= '0;
    end else begin
      if (cmd_i.append) len_q[str_q] <= n + 1'b1;
      if (cmd_i.len_dec) len_q[str_q] <= n - 1'b1;
      if (cmd_i.clr_len) len_q[str_q] <= '0;
      if (cmd_i.dec_rd && dk_q >= dlen) len_q[ds_q] <= dw_q;
    end
  end

  assign st_o.func = func_e'(func_q);
  assign st_o.ok = ok;
  assign st_o.scan_end = (k_q >= n);
  assign st_o.found = found_q;
  assign st_o.full = (n >= CntW'(cap)) && (n != '0);
  assign st_o.room = (n < CntW'(MaxSlots));
  assign st_o.shift_end = (k_q + 1'b1 >= n);
  assign st_o.stream_end = (dk_q >= dlen);
  assign st_o.dec_end = (ds_q >= StrW'(NumStreams));

  assign status_o = stat_q;
  assign evicted_o = ev_q;
  assign evicted_node_o = evn_q;
  assign dropped_count_o = drop_q;
  assign slot_valid_o = rv_q;
  assign slot_node_o = rn_q;
  assign slot_activation_o = ra_q;
  assign slot_attention_o = rt_q;
  assign slot_count_o = n;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |-> n < CntW'(MaxSlots)) else $error("append past end");
  a_div_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.dec_wr |-> quo_q < 24'd1048576) else $error("decay quotient range");
  a_shift_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift_step |-> k_q + 1'b1 < n) else $error("shift past list");

endmodule

// ===== rtl/decaying_working_set_table.sv =====
// Decaying working-set table: three streams of node slots with decay.
// Channels: s_axis (command), m_axis (result), cfg (slot capacity write,
// always ready). One command transaction is worked on at a time and the
// result is held in an output register while m_axis_tready is low.
// Load and remove scan the list and, when a slot is dropped, shift the slots
// behind it; a decay tick walks every live slot of each stream.
// s_axis_tready returns in the cycle after the result is loaded, so a new
// command is taken only once the last result is in the output register.
// Reset clears list lengths to zero and capacity to 4; slot contents are
// never cleared. While the receiver stalls, one more command is taken and
// worked on, then holds in its last step until the output register frees.
// tdata in:  func[2:0], stream[4:3], node_id[67:5], weight[83:68],
//            tick_length[99:84], slot_index[102:100], zero pad to 104 bits.
// tdata out: status[2:0], evicted[3], evicted_node[66:4],
//            dropped_count[71:67], slot_valid[72], slot_node[135:73],
//            slot_activation[151:136], slot_attention[167:152],
//            slot_count[171:168], zero pad to 176 bits.
module decaying_working_set_table import dwst_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,   // func, stream, node_id, weight, tick_length, slot_index
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [175:0] m_axis_tdata,   // status..slot_count, see header
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [3:0]   cfg_data
);

  logic [CapW-1:0] cap_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= CapReset;
    else if (cfg_valid) cap_q <= cfg_data;
  end
  assign cfg_ready = 1'b1;

  cmd_t  cmd;
  stat_t st;
  logic  out_v_q;
  logic [175:0] out_q;

  logic [2:0] status;
  logic evicted, slot_valid;
  logic [NodeW-1:0] evicted_node, slot_node;
  logic [4:0] dropped;
  logic [QW-1:0] sact, satt;
  logic [CntW-1:0] scnt;

  dwst_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_full_i(out_v_q && !m_axis_tready),
    .st_i(st), .cmd_o(cmd)
  );

  dwst_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .func_i(s_axis_tdata[2:0]), .stream_i(s_axis_tdata[4:3]),
    .node_id_i(s_axis_tdata[67:5]), .weight_i(s_axis_tdata[83:68]),
    .tick_length_i(s_axis_tdata[99:84]), .slot_index_i(s_axis_tdata[102:100]),
    .cap_i(cap_q), .st_o(st),
    .status_o(status), .evicted_o(evicted), .evicted_node_o(evicted_node),
    .dropped_count_o(dropped), .slot_valid_o(slot_valid),
    .slot_node_o(slot_node), .slot_activation_o(sact),
    .slot_attention_o(satt), .slot_count_o(scnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (cmd.out_load) out_v_q <= 1'b1;
    else if (m_axis_tready) out_v_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load)
      out_q <= {4'b0, scnt, satt, sact, slot_node, slot_valid, dropped,
                evicted_node, evicted, status};
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = out_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule
